>>> hw/rtl/tbri_pkg.sv
package tbri_pkg;

  // Default fixed-point format of the pixel path.
  localparam int FRAC_BITS_DEF  = 14;
  localparam int PIXEL_BITS_DEF = 16;

  // Fixed widths of the register file and of the result word.
  localparam int TRANS_W   = 15;
  localparam int PATH_W    = 15;
  localparam int ALBEDO_W  = 14;
  localparam int CODE_W    = 16;
  localparam int SURF_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Product of the two transmittances.
  localparam int TT_W = 2 * TRANS_W;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATH   = 3'd0,
    REG_DOWN   = 3'd1,
    REG_UP     = 3'd2,
    REG_ALBEDO = 3'd3,
    REG_NODATA = 3'd4
  } tbri_reg_t;

  // Pixel status codes.
  typedef enum logic [1:0] {
    ST_VALID  = 2'd0,
    ST_NODATA = 2'd1,
    ST_NOROOT = 2'd2,
    ST_REJECT = 2'd3
  } tbri_status_t;

  // Per-pixel decisions that travel down the pipeline with the data.
  typedef struct packed {
    logic last;
    logic reject;
    logic nodata;
    logic noroot;
    logic pos;
    logic sat;
  } tbri_flags_t;

  // Register reset values.
  localparam logic [PATH_W-1:0]   PATH_RST   = '0;
  localparam logic [TRANS_W-1:0]  TRANS_RST  = 15'd16384;
  localparam logic [ALBEDO_W-1:0] ALBEDO_RST = '0;
  localparam logic [CODE_W-1:0]   NODATA_RST = 16'hFFFF;

endpackage

>>> hw/rtl/toa_to_boa_reflectance_inversion.sv
// Per-pixel atmospheric correction: each top-of-atmosphere reflectance word
// becomes a surface reflectance clamped to 0..1.0, with status codes for a
// no-data pixel, a denominator of zero or less, and a zero transmittance.
// The block takes one pixel every clock while in_stall is low and returns
// results in order. Each pixel passes the front-end registers (subtract,
// albedo multiply, denominator add, range checks), the FRAC_BITS + 1 stage
// restoring divider, one quotient bit per stage, and the output register.
// A stall on the output freezes the whole pipeline and is seen at in_stall
// in the same cycle. Registers may be written only while no pixel is in
// flight; cfg_ready is always high.
module toa_to_boa_reflectance_inversion #(
  parameter int FRAC_BITS  = tbri_pkg::FRAC_BITS_DEF,
  parameter int PIXEL_BITS = tbri_pkg::PIXEL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Pixel input channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [PIXEL_BITS-1:0]            in_toa_pixel,
  input  logic                             in_last_pixel,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tbri_pkg::SURF_W-1:0]      out_surface_pixel,
  output logic [1:0]                       out_pixel_status,
  output logic                             out_last_out,
  // Register write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tbri_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tbri_pkg::CFG_DAT_W-1:0]   cfg_data
);

  // Signed difference, albedo product, denominator and divider widths.
  localparam int XW  = ((PIXEL_BITS > tbri_pkg::PATH_W) ? PIXEL_BITS : tbri_pkg::PATH_W) + 1;
  localparam int PW  = XW + tbri_pkg::ALBEDO_W + 1;
  localparam int DW  = ((PW > tbri_pkg::TT_W) ? PW : tbri_pkg::TT_W) + 2;
  localparam int CW  = (PIXEL_BITS > tbri_pkg::CODE_W) ? PIXEL_BITS : tbri_pkg::CODE_W;
  localparam int QW  = FRAC_BITS + 1;
  localparam int NS  = FRAC_BITS + 1;
  localparam int SW  = (QW > tbri_pkg::SURF_W) ? QW : tbri_pkg::SURF_W;
  localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

  // Configuration registers.
  logic [tbri_pkg::PATH_W-1:0]   path_r;
  logic [tbri_pkg::TRANS_W-1:0]  down_r;
  logic [tbri_pkg::TRANS_W-1:0]  up_r;
  logic [tbri_pkg::ALBEDO_W-1:0] albedo_r;
  logic [tbri_pkg::CODE_W-1:0]   nodata_r;
  logic [tbri_pkg::TT_W-1:0]     tt_r;

  // Pipeline advance: everything moves unless a held result is stalled.
  logic adv;

  // Front-end stage registers.
  logic                  s0_valid_r, s1_valid_r, s2_valid_r;
  tbri_pkg::tbri_flags_t s0_flags_r, s1_flags_r, s2_flags_r;
  logic signed [XW-1:0]  s0_x_r, s1_x_r, s2_x_r;
  logic signed [PW-1:0]  s1_p_r;
  logic signed [DW-1:0]  s2_den_r;

  // Divider stage registers; index 0 is loaded by the range-check stage.
  logic                  dv_valid_r [0:NS];
  tbri_pkg::tbri_flags_t dv_flags_r [0:NS];
  logic [DW-1:0]         dv_rem_r   [0:NS];
  logic [DW-1:0]         dv_den_r   [0:NS];
  logic [QW-1:0]         dv_q_r     [0:NS];

  // Output registers.
  logic                      out_valid_r;
  logic [tbri_pkg::SURF_W-1:0] out_surface_r;
  logic [1:0]                out_status_r;
  logic                      out_last_r;

  // Combinational helpers.
  logic signed [XW-1:0]  s0_x_nxt;
  tbri_pkg::tbri_flags_t s0_flags_nxt;
  logic signed [PW-1:0]  s1_p_nxt;
  logic signed [PW-1:0]  s2_p_sh;
  logic signed [DW-1:0]  s2_den_nxt;
  tbri_pkg::tbri_flags_t s3_flags_nxt;
  logic [DW:0]           s3_x_ext;
  logic [DW:0]           s3_den_x2;
  logic [SW-1:0]         out_surface_nxt;
  logic [1:0]            out_status_nxt;

  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // Register file writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_r   <= tbri_pkg::PATH_RST;
      down_r   <= tbri_pkg::TRANS_RST;
      up_r     <= tbri_pkg::TRANS_RST;
      albedo_r <= tbri_pkg::ALBEDO_RST;
      nodata_r <= tbri_pkg::NODATA_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tbri_pkg::REG_PATH:   path_r   <= cfg_data[tbri_pkg::PATH_W-1:0];
        tbri_pkg::REG_DOWN:   down_r   <= cfg_data[tbri_pkg::TRANS_W-1:0];
        tbri_pkg::REG_UP:     up_r     <= cfg_data[tbri_pkg::TRANS_W-1:0];
        tbri_pkg::REG_ALBEDO: albedo_r <= cfg_data[tbri_pkg::ALBEDO_W-1:0];
        tbri_pkg::REG_NODATA: nodata_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The transmittance product depends on registers only, so it is kept
  // precomputed and is ready long before a pixel reaches the adder.
  always_ff @(posedge clk) begin
    tt_r <= (tbri_pkg::TT_W'(down_r) * tbri_pkg::TT_W'(up_r)) >> FRAC_BITS;
  end

  // Stage 0: subtract the path reflectance and classify the pixel.
  always_comb begin
    s0_x_nxt = $signed({1'b0, (XW-1)'(in_toa_pixel)})
             - $signed({1'b0, (XW-1)'(path_r)});
    s0_flags_nxt        = '0;
    s0_flags_nxt.last   = in_last_pixel;
    s0_flags_nxt.reject = (down_r == '0) || (up_r == '0);
    s0_flags_nxt.nodata = (CW'(in_toa_pixel) == CW'(nodata_r));
  end

  // Stage 1: albedo times the signed difference.
  assign s1_p_nxt = PW'($signed({1'b0, albedo_r})) * PW'(s0_x_r);

  // Stage 2: floor-shifted product plus the transmittance term.
  always_comb begin
    s2_p_sh    = s1_p_r >>> FRAC_BITS;
    s2_den_nxt = $signed(DW'(tt_r)) + DW'(s2_p_sh);
  end

  // Stage 3: sign checks and the saturation test x >= 2 * denom, which
  // guarantees the remaining quotient fits in FRAC_BITS + 1 bits.
  always_comb begin
    s3_x_ext            = (DW+1)'(unsigned'(s2_x_r));
    s3_den_x2           = {s2_den_r, 1'b0};
    s3_flags_nxt        = s2_flags_r;
    s3_flags_nxt.noroot = (s2_den_r <= 0);
    s3_flags_nxt.pos    = (s2_x_r > 0);
    s3_flags_nxt.sat    = (s3_x_ext >= s3_den_x2);
  end

  // Front-end pipeline registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r    <= 1'b0;
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      dv_valid_r[0] <= 1'b0;
    end else if (adv) begin
      s0_valid_r    <= in_valid;
      s1_valid_r    <= s0_valid_r;
      s2_valid_r    <= s1_valid_r;
      dv_valid_r[0] <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_x_r        <= s0_x_nxt;
      s0_flags_r    <= s0_flags_nxt;
      s1_x_r        <= s0_x_r;
      s1_p_r        <= s1_p_nxt;
      s1_flags_r    <= s0_flags_r;
      s2_x_r        <= s1_x_r;
      s2_den_r      <= s2_den_nxt;
      s2_flags_r    <= s1_flags_r;
      dv_flags_r[0] <= s3_flags_nxt;
      dv_rem_r[0]   <= DW'(unsigned'(s2_x_r));
      dv_den_r[0]   <= unsigned'(s2_den_r);
      dv_q_r[0]     <= '0;
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  // The remainder stays below the denominator after each step, so the
  // doubled remainder always fits the register.
  for (genvar j = 0; j < NS; j++) begin : g_div
    logic          ge;
    logic [DW-1:0] sub;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    always_comb begin
      ge      = (dv_rem_r[j] >= dv_den_r[j]);
      sub     = ge ? (dv_rem_r[j] - dv_den_r[j]) : dv_rem_r[j];
      rem_nxt = {sub[DW-2:0], 1'b0};
      q_nxt   = dv_q_r[j];
      q_nxt[FRAC_BITS-j] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_valid_r[j+1] <= dv_valid_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_flags_r[j+1] <= dv_flags_r[j];
        dv_rem_r[j+1]   <= rem_nxt;
        dv_den_r[j+1]   <= dv_den_r[j];
        dv_q_r[j+1]     <= q_nxt;
      end
    end
  end

  // Result selection in priority order: reject, no-data, no root, value.
  always_comb begin
    out_surface_nxt = '0;
    out_status_nxt  = tbri_pkg::ST_VALID;
    if (dv_flags_r[NS].reject) begin
      out_status_nxt = tbri_pkg::ST_REJECT;
    end else if (dv_flags_r[NS].nodata) begin
      out_surface_nxt = SW'(nodata_r);
      out_status_nxt  = tbri_pkg::ST_NODATA;
    end else if (dv_flags_r[NS].noroot) begin
      out_status_nxt = tbri_pkg::ST_NOROOT;
    end else if (dv_flags_r[NS].pos) begin
      if (dv_flags_r[NS].sat || (dv_q_r[NS] > ONE)) begin
        out_surface_nxt = SW'(ONE);
      end else begin
        out_surface_nxt = SW'(dv_q_r[NS]);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_surface_r <= out_surface_nxt[tbri_pkg::SURF_W-1:0];
      out_status_r  <= out_status_nxt;
      out_last_r    <= dv_flags_r[NS].last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_surface_pixel = out_surface_r;
  assign out_pixel_status  = out_status_r;
  assign out_last_out      = out_last_r;

endmodule
